[sv/pvd_pkg.sv]
// Package for the prefix varint stream decoder: payload structs and constants.
// Used by every module of the decoder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pvd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned LenW    = 4;
  localparam int unsigned PosW    = 16;

  localparam logic [PosW-1:0]  PosMax  = 16'hFFFF;
  localparam logic [ByteW-1:0] TopBit  = 8'h80;
  localparam logic [ByteW-1:0] ByteMax = 8'hFF;

  localparam logic STATUS_COMPLETE  = 1'b0;
  localparam logic STATUS_TRUNCATED = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             buffer_end;
  } pvd_in_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [LenW-1:0]   length;
    logic              status;
    logic [PosW-1:0]   next_offset;
  } pvd_out_t;

endpackage
`default_nettype wire

[sv/pvd_in_stage.sv]
// Input register of the decoder: holds one accepted byte until the decode step takes it.
// Depends on pvd_pkg for the input payload type.
`timescale 1ns / 1ps
`default_nettype none
module pvd_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pvd_pkg::pvd_in_t in_data,
  input  wire logic            advance,
  output logic                 hold_valid,
  output pvd_pkg::pvd_in_t     hold_data
);

  logic             valid_r;
  logic             valid_nxt;
  pvd_pkg::pvd_in_t data_r;

  // Take a new byte when empty or when the held byte moves on this cycle
  assign in_ready   = !valid_r || advance;
  assign hold_valid = valid_r;
  assign hold_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // Control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

endmodule
`default_nettype wire

[sv/pvd_decode.sv]
// Decode step: prefix length count, value collection and buffer position tracking.
// Holds the open-integer state; depends on pvd_pkg for types and constants.
`timescale 1ns / 1ps
`default_nettype none
module pvd_decode (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire pvd_pkg::pvd_in_t item,
  output logic                  emit,
  output pvd_pkg::pvd_out_t     result
);

  logic [pvd_pkg::ValueW-1:0] acc_r,  acc_nxt;
  logic [pvd_pkg::LenW-1:0]   rem_r,  rem_nxt;
  logic [pvd_pkg::LenW-1:0]   seen_r, seen_nxt;
  logic                       busy_r, busy_nxt;
  logic [pvd_pkg::PosW-1:0]   pos_r,  pos_nxt;

  logic [pvd_pkg::LenW-1:0]   head_len;
  logic [pvd_pkg::ByteW-1:0]  head_mask;
  logic [pvd_pkg::ValueW-1:0] step_acc;
  logic [pvd_pkg::LenW-1:0]   step_rem;
  logic [pvd_pkg::LenW-1:0]   step_seen;
  logic [pvd_pkg::PosW-1:0]   step_pos;
  logic                       done;
  logic                       run;

  // Count leading ones of the first byte; encoded length is that plus one
  always_comb begin
    head_len = pvd_pkg::LenW'(1);
    run      = 1'b1;
    for (int i = pvd_pkg::ByteW - 1; i >= 0; i--) begin
      if (run && item.data_byte[i]) begin
        head_len = head_len + pvd_pkg::LenW'(1);
      end else begin
        run = 1'b0;
      end
    end
  end

  // Mask off prefix and separator bits; a nine-byte head keeps no value bits
  assign head_mask = (head_len > pvd_pkg::LenW'(pvd_pkg::ByteW)) ? '0 :
                     (pvd_pkg::ByteMax >> head_len);

  // Shift in the byte or start a new integer
  always_comb begin
    if (busy_r) begin
      step_acc  = {acc_r[pvd_pkg::ValueW-pvd_pkg::ByteW-1:0], item.data_byte};
      step_seen = seen_r + pvd_pkg::LenW'(1);
      step_rem  = rem_r - pvd_pkg::LenW'(1);
    end else begin
      step_acc  = {{(pvd_pkg::ValueW-pvd_pkg::ByteW){1'b0}}, item.data_byte & head_mask};
      step_seen = pvd_pkg::LenW'(1);
      step_rem  = head_len - pvd_pkg::LenW'(1);
    end
  end

  // Saturating position after this byte
  assign step_pos = (pos_r == pvd_pkg::PosMax) ? pvd_pkg::PosMax
                                               : pos_r + pvd_pkg::PosW'(1);
  assign done     = (step_rem == '0);
  assign emit     = done || item.buffer_end;

  // Result: full value on completion, zero with truncated status otherwise
  always_comb begin
    result.value       = done ? step_acc : '0;
    result.length      = step_seen;
    result.status      = done ? pvd_pkg::STATUS_COMPLETE : pvd_pkg::STATUS_TRUNCATED;
    result.next_offset = step_pos;
  end

  // Advance state; drop the open integer on emit, restart position at buffer end
  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    seen_nxt = seen_r;
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    if (fire) begin
      if (emit) begin
        acc_nxt  = '0;
        rem_nxt  = '0;
        seen_nxt = '0;
        busy_nxt = 1'b0;
      end else begin
        acc_nxt  = step_acc;
        rem_nxt  = step_rem;
        seen_nxt = step_seen;
        busy_nxt = 1'b1;
      end
      pos_nxt = item.buffer_end ? '0 : step_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      rem_r  <= '0;
      seen_r <= '0;
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      acc_r  <= acc_nxt;
      rem_r  <= rem_nxt;
      seen_r <= seen_nxt;
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/pvd_out_stage.sv]
// Result register of the decoder: holds one result until the receiver takes it.
// Depends on pvd_pkg for the result payload type.
`timescale 1ns / 1ps
`default_nettype none
module pvd_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire pvd_pkg::pvd_out_t load_data,
  output logic                   can_load,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pvd_pkg::pvd_out_t      out_data
);

  logic              valid_r;
  logic              valid_nxt;
  pvd_pkg::pvd_out_t data_r;

  // Free this cycle when empty or when the held result transfers
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      data_r <= load_data;
    end
  end

endmodule
`default_nettype wire

[sv/prefix_varint_stream_decoder_core.sv]
// Prefix varint stream decoder, top level.
// Input channel (in_valid/in_ready/in_data) carries one buffer byte per transfer with a
// flag marking the last byte of the buffer. The result channel (out_valid/out_ready/
// out_data) carries one decoded integer: value, encoded length, status and the buffer
// offset after it. A byte that neither completes an integer nor ends the buffer gives
// no result. An integer whose buffer ends early gives value 0 with truncated status.
// The byte first sits in the input register, then the decode step loads the result
// register, so a result passes through both registers before it can transfer.
// Throughput: one byte per cycle while the result register can take what the held
// byte yields, set by the combinational decode step between the two registers.
// While the result register is full and out_ready is low, the held byte waits whether
// or not it yields a result, so in_ready drops and the pipeline holds.
// Reset (rst_n low, synchronous) empties both registers, closes any open integer and
// restarts the buffer position at zero. The position saturates at 65535.
// Depends on pvd_pkg, pvd_in_stage, pvd_decode and pvd_out_stage.
`timescale 1ns / 1ps
`default_nettype none
module prefix_varint_stream_decoder_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pvd_pkg::pvd_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pvd_pkg::pvd_out_t      out_data
);

  logic              hold_valid;
  pvd_pkg::pvd_in_t  hold_data;
  logic              can_load;
  logic              advance;
  logic              fire;
  logic              emit;
  pvd_pkg::pvd_out_t result;

  // Move the held byte on when the result register can take whatever it yields
  assign advance = can_load;
  assign fire    = hold_valid && advance;

  pvd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  pvd_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (hold_data),
    .emit   (emit),
    .result (result)
  );

  pvd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && emit),
    .load_data (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Length of a shown result is between one and nine bytes
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.length != 4'd0) && (out_data.length <= 4'd9))
    else $error("result length out of range");

  // A truncated result carries a zero value
  a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == pvd_pkg::STATUS_TRUNCATED) |-> (out_data.value == '0))
    else $error("truncated result with nonzero value");

  // A complete one-byte integer fits in seven bits
  a_short_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == pvd_pkg::STATUS_COMPLETE) && (out_data.length == 4'd1)
    |-> (out_data.value < 64'd128))
    else $error("one-byte integer exceeds seven bits");

endmodule
`default_nettype wire
